/* hdl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// PTP sync servo package
// Shared types, codes and constants for the clock servo.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned HistoryDepthDefault = 32;
  localparam logic signed [15:0] EmptyEntry = 16'sh8000;
  localparam logic [63:0] EpochFloor = 64'd1633942188395;

  typedef enum logic [1:0] {
    OP_SYNC = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PORT_EVENT   = 2'd0,
    PORT_GENERAL = 2'd1,
    PORT_OTHER   = 2'd2,
    PORT_RSVD    = 2'd3
  } port_t;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_RESYNC = 3'd2,
    ST_HELD   = 3'd3,
    ST_TICK   = 3'd4,
    ST_READ   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_ACCEPT_WINDOW = 2'd0,
    REG_SETTLE_TIME   = 2'd1,
    REG_LOCK_TIMEOUT  = 2'd2,
    REG_NONE          = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_FIRST,
    S_CHECK,
    S_STORE,
    S_SCAN,
    S_SETTLE,
    S_SHIFT,
    S_SERVO,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic clear_done_ack;
    logic decode;
    logic mul;
    logic first;
    logic check;
    logic store;
    logic scan_step;
    logic settle;
    logic shift_step;
    logic servo;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_sync;
    logic held;
    logic rejected;
    logic resync;
    logic scan_done;
    logic do_settle;
    logic shift_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [1:0]  port_kind;
    logic        two_step_flag;
    logic [15:0] sequence_id;
    logic [15:0] seconds_high;
    logic [31:0] seconds_low;
    logic [29:0] nanoseconds;
    logic signed [3:0] log_interval;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  packet_status;
    logic        lock_status;
    logic        epoch_valid;
    logic signed [15:0] last_peak_diff;
    logic [31:0] synced_ms;
    logic [63:0] epoch_ms;
  } out_word_t;

endpackage

/* hdl/pss_if.sv */
// ----------------------------------------------------------------------------
// Servo channel interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface pss_in_if (input logic clk);
  logic valid;
  logic ready;
  pss_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pss_out_if (input logic clk);
  logic valid;
  logic ready;
  pss_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/pss_ctrl.sv */
// ----------------------------------------------------------------------------
// Servo controller
// Sequences clearing, packet processing, scans and result hand-off.
// ----------------------------------------------------------------------------
module pss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pss_pkg::sts_t  sts,
  output pss_pkg::cmd_t  cmd
);
  import pss_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          cmd.clear_done_ack = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (!sts.is_sync || sts.held) state_next = S_OUT;
        else state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_FIRST;
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.rejected) state_next = S_OUT;
        else state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_SETTLE;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        if (sts.do_settle) state_next = S_SHIFT;
        else state_next = S_SERVO;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_next = S_SERVO;
      end
      S_SERVO: begin
        cmd.servo = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = sts.resync ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

/* hdl/pss_dp.sv */
// ----------------------------------------------------------------------------
// Servo datapath
// Servo state, history memory, peak scan and output register.
// ----------------------------------------------------------------------------
module pss_dp #(
  parameter int unsigned HISTORY_DEPTH = pss_pkg::HistoryDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_take,
  input  pss_pkg::in_word_t in_data,
  input  pss_pkg::cmd_t     cmd,
  output pss_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_pkg::out_word_t out_data
);
  import pss_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);
  // ns / 1e6 as (ns >> 6) / 15625 by reciprocal multiply, exact for 24-bit input
  localparam logic [24:0] MsRecip = 25'd17592187;
  localparam int unsigned MsShift = 38;

  // configuration
  logic [14:0] accept_window_ms;
  logic [15:0] settle_time_ms, lock_timeout_ms;

  // servo state
  logic        two_step_mode, first_packet_pending, fast_start_mode, settle_pending;
  logic        epoch_plausible_raw, epoch_plausible, locked;
  logic [15:0] held_sequence, reject_run, accept_count;
  logic [31:0] held_receive_time, settle_start_time, last_nudge_time;
  logic [31:0] working_offset, confident_offset, last_accept_time, last_returned_time;
  logic [63:0] working_epoch_offset, confident_epoch_offset;
  logic [AW-1:0] history_pointer;
  logic signed [15:0] peak_register;

  // item scratch
  in_word_t    item;
  logic [2:0]  status;
  logic [31:0] synced;
  logic        is_sync, held, rejected, was_settling, resync_pend;
  logic [31:0] extra, ms_frac, ptp;
  logic [63:0] ptp64;
  logic signed [31:0] diff;
  logic signed [15:0] peak;
  logic [AW:0] scan_cnt, scan_len;
  logic [AW-1:0] scan_idx, rd_addr, wr_addr;
  logic [AW:0] clr_cnt;

  // history memory
  logic signed [15:0] hist [HISTORY_DEPTH];
  logic signed [15:0] rd_data;
  logic        wr_en;
  logic signed [15:0] wr_data;
  logic        rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) hist[wr_addr] <= wr_data;
    rd_data <= hist[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_window_ms <= 15'd200;
      settle_time_ms <= 16'd1500;
      lock_timeout_ms <= 16'd5000;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_ACCEPT_WINDOW: accept_window_ms <= cfg_data[14:0];
        REG_SETTLE_TIME:   settle_time_ms <= cfg_data;
        REG_LOCK_TIMEOUT:  lock_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // combinational helpers
  logic [31:0] now;
  logic [31:0] mag;
  logic signed [4:0] logi_n;
  logic [15:0] rej_inc;
  logic [31:0] rej_limit, win_len;
  logic [15:0] apeak;
  logic [31:0] interval;
  logic signed [15:0] peak_after;
  logic        settle_now;
  logic [31:0] ret;
  logic [31:0] rdiff;
  logic        dec_sync, dec_two, dec_held;
  logic [48:0] ns_prod;

  assign now = item.now_ms;
  assign logi_n = -{item.log_interval[3], item.log_interval};
  assign mag = diff[31] ? 32'd0 - 32'(diff) : 32'(diff);
  assign rejected = mag > {17'd0, accept_window_ms};
  assign rej_inc = (reject_run != 16'hFFFF) ? reject_run + 16'd1 : reject_run;
  assign rej_limit = (item.log_interval < -4'sd2) ? (32'd4 << logi_n[3:0]) : 32'd16;
  assign win_len = (item.log_interval <= -4'sd2) ? (32'd4 << logi_n[3:0]) : 32'd8;
  assign settle_now = !first_packet_pending && settle_pending &&
                      ((now - settle_start_time) > {16'd0, settle_time_ms});
  assign peak_after = settle_now ? 16'sd0 : peak;
  assign apeak = peak_after[15] ? 16'd0 - peak_after : peak_after;
  assign ret = now + confident_offset;
  assign rdiff = ret - last_returned_time;
  assign ns_prod = 49'(item.nanoseconds[29:6]) * 49'(MsRecip);

  // classify the waiting word
  assign dec_sync = op_t'(item.operation) == OP_SYNC;
  assign dec_two = (port_t'(item.port_kind) == PORT_EVENT) ? item.two_step_flag
                                                           : two_step_mode;
  assign dec_held = dec_sync && dec_two &&
                    ((port_t'(item.port_kind) == PORT_EVENT) ||
                     ((port_t'(item.port_kind) == PORT_GENERAL) &&
                      (item.sequence_id != held_sequence)));

  always_comb begin
    interval = 32'd5000;
    if (apeak >= 16'd3) interval = 32'd2000;
    if (apeak >= 16'd10) interval = 32'd1000;
    if (fast_start_mode && apeak >= 16'd20) interval = 32'd250;
    if (fast_start_mode && apeak >= 16'd40) interval = 32'd125;
  end

  // memory port steering
  always_comb begin
    wr_en = 1'b0;
    wr_addr = history_pointer;
    wr_data = 16'(diff);
    rd_addr = scan_idx;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
      wr_data = EmptyEntry;
    end else if (cmd.store) begin
      wr_en = 1'b1;
    end else if (cmd.shift_step && rd_valid && !sts.shift_done) begin
      wr_en = (rd_data != EmptyEntry);
      wr_addr = scan_idx - AW'(1);
      wr_data = rd_data - peak;
    end
  end

  assign sts.clear_done = clr_cnt == (AW+1)'(HISTORY_DEPTH);
  assign sts.is_sync = dec_sync;
  assign sts.held = dec_held;
  assign sts.rejected = rejected;
  assign sts.resync = resync_pend;
  assign sts.scan_done = rd_valid && (scan_cnt == scan_len);
  assign sts.do_settle = settle_now;
  assign sts.shift_done = rd_valid && (scan_cnt == (AW+1)'(HISTORY_DEPTH));
  assign sts.out_free = !out_valid || out_ready;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      two_step_mode <= 1'b0; held_sequence <= '0; held_receive_time <= '0;
      first_packet_pending <= 1'b1; fast_start_mode <= 1'b1; settle_pending <= 1'b0;
      settle_start_time <= '0; last_nudge_time <= '0; working_offset <= '0;
      working_epoch_offset <= '0; confident_offset <= '0; confident_epoch_offset <= '0;
      epoch_plausible_raw <= 1'b0; epoch_plausible <= 1'b0; locked <= 1'b0;
      reject_run <= '0; accept_count <= '0; history_pointer <= '0;
      peak_register <= '0; last_accept_time <= '0; last_returned_time <= '0;
      clr_cnt <= '0; out_valid <= 1'b0; rd_valid <= 1'b0; resync_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      // clearing sweep
      if (cmd.clear_step && !sts.clear_done) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.clear_done_ack) clr_cnt <= '0;
      if (in_take) item <= in_data;
      // decode operation
      if (cmd.decode) begin
        is_sync <= 1'b0; held <= 1'b0; synced <= '0; extra <= '0;
        resync_pend <= 1'b0;
        status <= ST_HELD;
        unique case (op_t'(item.operation))
          OP_SYNC: begin
            is_sync <= 1'b1;
            if (port_t'(item.port_kind) == PORT_EVENT) two_step_mode <= item.two_step_flag;
            if ((port_t'(item.port_kind) == PORT_EVENT) ? item.two_step_flag : two_step_mode) begin
              if (port_t'(item.port_kind) == PORT_EVENT) begin
                held_sequence <= item.sequence_id;
                held_receive_time <= now;
                held <= 1'b1;
              end else if (port_t'(item.port_kind) == PORT_GENERAL) begin
                if (item.sequence_id != held_sequence) held <= 1'b1;
                extra <= now - held_receive_time;
              end
            end
          end
          OP_TICK: begin
            status <= ST_TICK;
            if (locked && (now - last_accept_time) > {16'd0, lock_timeout_ms})
              locked <= 1'b0;
          end
          OP_READ: begin
            status <= ST_READ;
            if (rdiff[31] && (rdiff > 32'hFFFF_FC18)) synced <= last_returned_time;
            else begin
              last_returned_time <= ret;
              synced <= ret;
            end
          end
          default: ;
        endcase
        ms_frac <= 32'(ns_prod[48:MsShift]);
      end
      // timestamp products
      if (cmd.mul) begin
        ptp <= item.seconds_low * 32'd1000 + ms_frac + extra;
        ptp64 <= {item.seconds_high, item.seconds_low} * 64'd1000 + {32'd0, ms_frac}
                 + {32'd0, extra};
      end
      // first packet capture
      if (cmd.first) begin
        if (first_packet_pending) begin
          working_offset <= ptp - now;
          last_nudge_time <= now;
          settle_pending <= 1'b1;
          settle_start_time <= now;
          epoch_plausible_raw <= ptp64 > EpochFloor;
          working_epoch_offset <= ptp64 - {32'd0, ptp};
          diff <= '0;
        end else begin
          diff <= ptp - working_offset - now;
        end
      end
      // window check
      if (cmd.check) begin
        if (rejected) begin
          reject_run <= rej_inc;
          status <= ST_REJECT;
          if ({16'd0, rej_inc} > rej_limit) begin
            status <= ST_RESYNC;
            resync_pend <= 1'b1;
            first_packet_pending <= 1'b1; fast_start_mode <= 1'b1;
            last_nudge_time <= now; history_pointer <= '0;
            reject_run <= '0; accept_count <= '0; locked <= 1'b0;
          end
        end else begin
          reject_run <= '0;
        end
      end
      // store and start scan
      if (cmd.store) begin
        history_pointer <= (history_pointer == LastIdx) ? '0 : history_pointer + 1'b1;
        scan_idx <= history_pointer;
        scan_cnt <= '0;
        rd_valid <= 1'b0;
        scan_len <= (win_len > 32'(HISTORY_DEPTH)) ? (AW+1)'(HISTORY_DEPTH)
                                                   : (AW+1)'(win_len);
        peak <= EmptyEntry;
        status <= ST_ACCEPT;
      end
      // peak scan, one entry per cycle
      if (cmd.scan_step) begin
        if (rd_valid && !sts.scan_done && rd_data > peak) peak <= rd_data;
        if (rd_valid) scan_cnt <= scan_cnt + 1'b1;
        rd_valid <= 1'b1;
        scan_idx <= (scan_idx == '0) ? LastIdx : scan_idx - 1'b1;
        if (sts.scan_done) rd_valid <= 1'b0;
      end
      if (cmd.settle) begin
        peak_register <= peak;
        was_settling <= settle_pending;
        scan_idx <= '0;
        scan_cnt <= '0;
        rd_valid <= 1'b0;
        if (settle_now) begin
          settle_pending <= 1'b0;
          working_offset <= working_offset + 32'(peak);
        end
      end
      // settle shift sweep
      if (cmd.shift_step) begin
        rd_valid <= 1'b1;
        if (rd_valid) scan_cnt <= scan_cnt + 1'b1;
        scan_idx <= scan_idx + 1'b1;
        if (sts.shift_done) begin
          rd_valid <= 1'b0;
          peak <= 16'sd0;
        end
      end
      // servo nudges and lock
      if (cmd.servo && !was_settling) begin
        if (accept_count >= 16'd5) begin
          if (fast_start_mode && apeak < 16'd10) fast_start_mode <= 1'b0;
          if (!locked) begin
            if (apeak < 16'd10) locked <= 1'b1;
          end else if (apeak > 16'd20) locked <= 1'b0;
        end
        if ((now - last_nudge_time) >= interval) begin
          last_nudge_time <= now;
          if (peak > 16'sd1) working_offset <= working_offset + 32'd1;
          else if (peak < -16'sd1) working_offset <= working_offset - 32'd1;
        end
      end
      if (cmd.finish) begin
        if (!was_settling) begin
          confident_offset <= working_offset;
          confident_epoch_offset <= working_epoch_offset;
          epoch_plausible <= epoch_plausible_raw;
        end
        last_accept_time <= now;
        if (accept_count != 16'hFFFF) accept_count <= accept_count + 16'd1;
        first_packet_pending <= 1'b0;
      end
      // result register
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        out_data.packet_status <= (is_sync && held) ? ST_HELD : status;
        out_data.lock_status <= locked;
        out_data.epoch_valid <= epoch_plausible;
        out_data.last_peak_diff <= peak_register;
        out_data.synced_ms <= synced;
        out_data.epoch_ms <= {32'd0, now + confident_offset} + confident_epoch_offset;
      end
    end
  end

endmodule

/* hdl/ptp_sync_clock_servo.sv */
// ----------------------------------------------------------------------------
// PTP sync clock servo
// Reads, ticks and held or ignored packets go from decode straight to the result;
// rejected packets stop after the window check; accepted packets run the window
// scan and the servo steps, with a sweep of the whole history on a settle jump.
// One word at a time; the next word is taken in the cycle after the result loads,
// or later if it waits. After reset and after each resync result, a clearing pass
// fills history with the empty mark before the next word is taken.
// ----------------------------------------------------------------------------
module ptp_sync_clock_servo #(
  parameter int unsigned HISTORY_DEPTH = pss_pkg::HistoryDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pss_in_if.sink      in_ch,
  pss_out_if.source   out_ch
);
  import pss_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_take;

  assign in_take = in_ch.valid && in_ch.ready;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pss_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

/* tb/ptp_sync_clock_servo_checker.sv */
// ----------------------------------------------------------------------------
// PTP sync clock servo checker
// Watches the config port and both channels, keeps its own copy of the servo
// state, predicts one result word per accepted input word and compares every
// output word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptp_sync_clock_servo_checker
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pss_in_if           in_ch,
  pss_out_if          out_ch,
  output int          pending,
  output int          errors
);

  localparam int Depth = 32;

  // Register copies
  logic [14:0] window_ms;
  logic [15:0] settle_ms;
  logic [15:0] timeout_ms;

  // Servo state copy
  bit                 two_step;
  logic [15:0]        held_seq;
  logic [31:0]        held_rx_ms;
  bit                 first_pend;
  bit                 fast_start;
  bit                 settle_pend;
  logic [31:0]        settle_start_ms;
  logic [31:0]        last_nudge_ms;
  logic [31:0]        work_ofs;
  logic [63:0]        work_epoch_ofs;
  logic [31:0]        conf_ofs;
  logic [63:0]        conf_epoch_ofs;
  bit                 epoch_raw;
  bit                 epoch_ok;
  bit                 locked;
  logic [15:0]        reject_run;
  logic [15:0]        accept_cnt;
  logic signed [15:0] diff_hist [Depth];
  logic [4:0]         hist_ptr;
  logic signed [15:0] peak_reg;
  logic [31:0]        last_accept_ms;
  logic [31:0]        last_synced_ms;

  out_word_t servo_results_q[$];
  int        fail_count = 0;

  assign errors = fail_count;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_hist();
    for (int k = 0; k < Depth; k++) diff_hist[k] = EmptyEntry;
    hist_ptr = '0;
  endfunction

  function automatic void servo_reset();
    window_ms = 15'd200;
    settle_ms = 16'd1500;
    timeout_ms = 16'd5000;
    two_step = 0;
    held_seq = '0;
    held_rx_ms = '0;
    first_pend = 1;
    fast_start = 1;
    settle_pend = 0;
    settle_start_ms = '0;
    last_nudge_ms = '0;
    work_ofs = '0;
    work_epoch_ofs = '0;
    conf_ofs = '0;
    conf_epoch_ofs = '0;
    epoch_raw = 0;
    epoch_ok = 0;
    locked = 0;
    reject_run = '0;
    accept_cnt = '0;
    clear_hist();
    peak_reg = '0;
    last_accept_ms = '0;
    last_synced_ms = '0;
  endfunction

  // Run one sync message through the servo and return its status
  function automatic status_t servo_sync(in_word_t w);
    logic [31:0]        extra;
    logic [31:0]        nano_ms;
    logic [31:0]        ptp;
    logic [31:0]        mag;
    logic [31:0]        limit;
    logic [31:0]        interval;
    logic [31:0]        local_ofs;
    logic [63:0]        ptp64;
    logic signed [31:0] diff;
    logic signed [15:0] pk;
    int                 logi;
    int                 depth;
    int                 idx;
    int                 apeak;
    bit                 was_settling;
    extra = '0;
    logi = int'($signed(w.log_interval));
    if (w.port_kind == PORT_EVENT) two_step = w.two_step_flag;
    if (two_step) begin
      if (w.port_kind == PORT_EVENT) begin
        held_seq = w.sequence_id;
        held_rx_ms = w.now_ms;
        return ST_HELD;
      end
      if (w.port_kind == PORT_GENERAL) begin
        if (w.sequence_id != held_seq) return ST_HELD;
        extra = w.now_ms - held_rx_ms;
      end
    end

    nano_ms = 32'(w.nanoseconds) / 32'd1000000;
    ptp = w.seconds_low * 32'd1000 + nano_ms + extra;
    ptp64 = 64'({w.seconds_high, w.seconds_low}) * 64'd1000 + 64'(nano_ms) + 64'(extra);

    // Adopt the first packet as the working offset
    if (first_pend) begin
      work_ofs = ptp - w.now_ms;
      last_nudge_ms = w.now_ms;
      settle_pend = 1;
      settle_start_ms = w.now_ms;
      epoch_raw = ptp64 > EpochFloor;
      local_ofs = w.now_ms + work_ofs;
      work_epoch_ofs = ptp64 - 64'(local_ofs);
    end

    // Accept window and reject run
    diff = $signed(ptp - work_ofs - w.now_ms);
    mag = diff[31] ? 32'd0 - diff : diff;
    if (mag > 32'(window_ms)) begin
      limit = 32'd16;
      if (reject_run != 16'hFFFF) reject_run++;
      if (logi < -2) limit = 32'd4 << (-logi);
      if (32'(reject_run) > limit) begin
        first_pend = 1;
        fast_start = 1;
        last_nudge_ms = w.now_ms;
        clear_hist();
        reject_run = '0;
        accept_cnt = '0;
        locked = 0;
        return ST_RESYNC;
      end
      return ST_REJECT;
    end
    reject_run = '0;

    // Store and search the recent window for its peak
    diff_hist[hist_ptr] = diff[15:0];
    hist_ptr++;
    depth = 8;
    if (logi <= -2) depth = 4 << (-logi);
    if (depth > Depth) depth = Depth;
    idx = (int'(hist_ptr) + Depth - 1) % Depth;
    pk = EmptyEntry;
    for (int k = 0; k < depth; k++) begin
      if (pk < diff_hist[idx]) pk = diff_hist[idx];
      idx = (idx == 0) ? Depth - 1 : idx - 1;
    end

    interval = 32'd5000;
    peak_reg = pk;
    was_settling = settle_pend;

    // Single settle jump, shifting the stored history by the peak
    if (!first_pend && settle_pend && (w.now_ms - settle_start_ms) > 32'(settle_ms)) begin
      settle_pend = 0;
      work_ofs = work_ofs + {{16{pk[15]}}, pk};
      for (int k = 0; k < Depth; k++)
        if (diff_hist[k] != EmptyEntry) diff_hist[k] = diff_hist[k] - pk;
      pk = '0;
    end

    // Nudge and lock tracking
    if (!was_settling) begin
      apeak = pk[15] ? -int'(pk) : int'(pk);
      if (apeak >= 3) interval = 32'd2000;
      if (apeak >= 10) interval = 32'd1000;
      if (fast_start) begin
        if (apeak >= 20) interval = 32'd250;
        if (apeak >= 40) interval = 32'd125;
      end
      if (accept_cnt >= 16'd5) begin
        if (fast_start && apeak < 10) fast_start = 0;
        if (!locked) begin
          if (apeak < 10) locked = 1;
        end else if (apeak > 20) begin
          locked = 0;
        end
      end
      if ((w.now_ms - last_nudge_ms) >= interval) begin
        last_nudge_ms = w.now_ms;
        if (pk > 16'sd1) work_ofs++;
        else if (pk < -16'sd1) work_ofs--;
      end
      conf_ofs = work_ofs;
      conf_epoch_ofs = work_epoch_ofs;
      epoch_ok = epoch_raw;
    end

    last_accept_ms = w.now_ms;
    if (accept_cnt != 16'hFFFF) accept_cnt++;
    first_pend = 0;
    return ST_ACCEPT;
  endfunction

  function automatic out_word_t servo_result(in_word_t w);
    out_word_t          r;
    logic [31:0]        ret;
    logic signed [31:0] d;
    r = '0;
    r.packet_status = ST_HELD;
    case (op_t'(w.operation))
      OP_SYNC: r.packet_status = servo_sync(w);
      OP_TICK: begin
        if (locked && (w.now_ms - last_accept_ms) > 32'(timeout_ms)) locked = 0;
        r.packet_status = ST_TICK;
      end
      OP_READ: begin
        ret = w.now_ms + conf_ofs;
        d = $signed(ret - last_synced_ms);
        // Hold the last value on a small step back
        if (d < 0 && d > -32'sd1000) begin
          r.synced_ms = last_synced_ms;
        end else begin
          last_synced_ms = ret;
          r.synced_ms = ret;
        end
        r.packet_status = ST_READ;
      end
      default: ;
    endcase
    ret = w.now_ms + conf_ofs;
    r.lock_status = locked;
    r.epoch_valid = epoch_ok;
    r.last_peak_diff = peak_reg;
    r.epoch_ms = 64'(ret) + conf_epoch_ofs;
    return r;
  endfunction

  // Predict on accepted input words, compare on accepted output words
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst) begin
      servo_reset();
      servo_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_index))
          REG_ACCEPT_WINDOW: window_ms = cfg_data[14:0];
          REG_SETTLE_TIME:   settle_ms = cfg_data;
          REG_LOCK_TIMEOUT:  timeout_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) servo_results_q.push_back(servo_result(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (servo_results_q.size() == 0) begin
          report_mismatch("unexpected word", got.packet_status, '0);
        end else begin
          want = servo_results_q.pop_front();
          if (got.packet_status !== want.packet_status)
            report_mismatch("packet_status", got.packet_status, want.packet_status);
          if (got.lock_status !== want.lock_status)
            report_mismatch("lock_status", got.lock_status, want.lock_status);
          if (got.epoch_valid !== want.epoch_valid)
            report_mismatch("epoch_valid", got.epoch_valid, want.epoch_valid);
          if (got.last_peak_diff !== want.last_peak_diff)
            report_mismatch("last_peak_diff", got.last_peak_diff, want.last_peak_diff);
          if (got.synced_ms !== want.synced_ms)
            report_mismatch("synced_ms", got.synced_ms, want.synced_ms);
          if (got.epoch_ms !== want.epoch_ms)
            report_mismatch("epoch_ms", got.epoch_ms, want.epoch_ms);
        end
      end
    end
    pending = servo_results_q.size();
  end

endmodule

/* tb/ptp_sync_clock_servo_tb.sv */
// ----------------------------------------------------------------------------
// PTP sync clock servo testbench
// Drives directed and random sync, tick, read and no-op words through the servo
// with random gaps and stalls on both channels, across several register
// settings; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptp_sync_clock_servo_tb;
  import pss_pkg::*;

  localparam int CycleLimit = 1500000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending;
  int          errors;
  int          cycles = 0;

  // Master time model
  logic [31:0] clock_ms;
  logic [63:0] master_ofs;
  bit          sender_calm;
  bit          hold_go = 0;

  pss_in_if  in_ch (clk);
  pss_out_if out_ch (clk);

  ptp_sync_clock_servo i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ptp_sync_clock_servo_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("ptp_sync_clock_servo regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int  stall_left;
    int  hold_cnt;
    int  calm_cnt;
    bit  calm;
    bit  hold_done;
    bit  nxt;
    stall_left = 0;
    hold_cnt = 0;
    calm_cnt = 0;
    calm = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      calm_cnt++;
      if (calm_cnt == 300) begin
        calm_cnt = 0;
        calm = ($urandom_range(0, 3) == 0);
      end
      if (hold_go && !hold_done) begin
        hold_cnt++;
        nxt = 1'b0;
        if (hold_cnt == 400) hold_done = 1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
        if (!calm && $urandom_range(0, 9) == 0)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
      end
      out_ch.ready <= nxt;
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic offer_word(in_word_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = 0;
    if (!sender_calm && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_word_t noise_word(op_t op, logic [31:0] t);
    in_word_t w;
    w.operation = op;
    w.now_ms = t;
    w.port_kind = port_t'($urandom_range(0, 3));
    w.two_step_flag = 1'($urandom_range(0, 1));
    w.sequence_id = 16'($urandom_range(0, 65535));
    w.seconds_high = 16'($urandom_range(0, 65535));
    w.seconds_low = $urandom;
    w.nanoseconds = 30'($urandom_range(0, 999999999));
    w.log_interval = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic in_word_t sync_word(logic [31:0] t, logic [63:0] origin, port_t port,
                                         bit two, logic [15:0] seq, logic [3:0] logi);
    in_word_t    w;
    logic [63:0] sec;
    w = noise_word(OP_SYNC, t);
    sec = origin / 64'd1000;
    w.port_kind = port;
    w.two_step_flag = two;
    w.sequence_id = seq;
    w.seconds_high = sec[47:32];
    w.seconds_low = sec[31:0];
    w.nanoseconds = 30'((origin % 64'd1000) * 64'd1000000) + 30'($urandom_range(0, 999999));
    w.log_interval = logi;
    return w;
  endfunction

  function automatic logic [63:0] origin_now(logic [31:0] t);
    return 64'(t) + master_ofs + 64'($urandom_range(0, 10)) - 64'd5;
  endfunction

  function automatic logic [3:0] pick_logi();
    logic [3:0] v;
    case ($urandom_range(0, 9))
      0: v = 4'($urandom_range(0, 15));
      1: v = 4'hD;
      2: v = 4'hE;
      3: v = 4'hF;
      4: v = 4'h1;
      default: v = 4'h0;
    endcase
    return v;
  endfunction

  // Write all three registers, one per cycle
  task automatic set_regs(logic [15:0] win, logic [15:0] settle, logic [15:0] timeout);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACCEPT_WINDOW;
    cfg_data <= win;
    @(posedge clk);
    cfg_index <= REG_SETTLE_TIME;
    cfg_data <= settle;
    @(posedge clk);
    cfg_index <= REG_LOCK_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain results, then let the block finish any trailing work
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed sync streams, some noise and bursts
  task automatic random_phase(int items, bit with_hold);
    int          sel;
    int          n;
    logic [15:0] seq;
    logic [3:0]  logi;
    logic [63:0] origin;
    n = 0;
    while (n < items) begin
      if (with_hold && n >= items / 3) hold_go <= 1'b1;
      if ($urandom_range(0, 99) < 2) master_ofs = master_ofs + 64'($urandom_range(300, 9000));
      if ($urandom_range(0, 9) == 0) master_ofs = master_ofs + 64'($urandom_range(0, 2)) - 64'd1;
      sel = $urandom_range(0, 99);
      logi = pick_logi();
      if (sel < 45) begin
        if ($urandom_range(0, 9) < 6)
          offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b0,
                               16'($urandom_range(0, 65535)), logi));
        else
          offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_OTHER,
                               1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), logi));
      end else if (sel < 65) begin
        seq = 16'($urandom_range(0, 65535));
        origin = origin_now(clock_ms);
        offer_word(sync_word(clock_ms, origin, PORT_EVENT, 1'b1, seq, logi));
        clock_ms = clock_ms + $urandom_range(0, 50);
        if ($urandom_range(0, 9) == 0) seq = seq + 16'd1;
        offer_word(sync_word(clock_ms, origin, PORT_GENERAL, 1'($urandom_range(0, 1)), seq,
                             logi));
        n++;
      end else if (sel < 75) begin
        offer_word(noise_word(OP_TICK, clock_ms));
      end else if (sel < 85) begin
        if ($urandom_range(0, 2) == 0)
          offer_word(noise_word(OP_READ, clock_ms - $urandom_range(1, 999)));
        else
          offer_word(noise_word(OP_READ, clock_ms));
      end else if (sel < 90) begin
        offer_word(noise_word(OP_NONE, clock_ms));
      end else begin
        offer_word(noise_word(OP_SYNC, clock_ms));
      end
      n++;
      case ($urandom_range(0, 49))
        0: clock_ms = clock_ms + $urandom_range(5000, 70000);
        1: ;
        default: clock_ms = clock_ms + $urandom_range(1, 400);
      endcase
    end
  endtask

  initial begin
    in_word_t w;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ACCEPT_WINDOW;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    sender_calm = 0;
    clock_ms = 32'd1000;
    master_ofs = 64'd1700000000000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle ops, first packet, rejects, extremes, two-step cases
    offer_word(noise_word(OP_READ, clock_ms));
    offer_word(noise_word(OP_TICK, clock_ms));
    offer_word(noise_word(OP_NONE, clock_ms));
    offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b0, 16'd0, 4'h0));
    clock_ms += 100;
    offer_word(sync_word(clock_ms, origin_now(clock_ms) + 64'd100000, PORT_EVENT, 1'b0,
                         16'hFFFF, 4'h8));
    w = sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b0, 16'hFFFF, 4'h8);
    w.seconds_high = 16'hFFFF;
    w.seconds_low = 32'hFFFF_FFFF;
    w.nanoseconds = 30'd999999999;
    offer_word(w);
    offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b0, 16'd1, 4'h7));
    clock_ms += 100;
    offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b1, 16'd5, 4'h0));
    offer_word(sync_word(clock_ms + 5, origin_now(clock_ms), PORT_GENERAL, 1'b0, 16'd6, 4'h0));
    offer_word(sync_word(clock_ms + 9, origin_now(clock_ms), PORT_GENERAL, 1'b0, 16'd5, 4'h0));
    clock_ms += 2000;
    offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_OTHER, 1'b1, 16'd7, 4'h0));
    clock_ms += 2000;
    offer_word(sync_word(clock_ms, origin_now(clock_ms), PORT_EVENT, 1'b0, 16'd8, 4'hE));
    offer_word(noise_word(OP_READ, clock_ms));
    offer_word(noise_word(OP_READ, clock_ms - 500));
    offer_word(noise_word(OP_READ, clock_ms - 5000));
    clock_ms += 60000;
    offer_word(noise_word(OP_TICK, clock_ms));
    drain();

    // Reset settings, with the long receiver hold-off
    set_regs(16'd200, 16'd1500, 16'd5000);
    random_phase(250, 1'b1);
    drain();

    // Widest window, no settle wait, zero lock timeout; no sender gaps
    set_regs(16'h7FFF, 16'd0, 16'd0);
    sender_calm = 1;
    clock_ms = $urandom;
    master_ofs = 64'($urandom_range(100, 100000));
    random_phase(150, 1'b0);
    drain();

    // Narrowest nonzero window, longest waits, across the counter wrap
    set_regs(16'd1, 16'hFFFF, 16'hFFFF);
    sender_calm = 0;
    clock_ms = 32'hFFFF_0000;
    master_ofs = 64'd1700000000000 + 64'($urandom);
    random_phase(150, 1'b0);
    drain();

    // Zero window
    set_regs(16'd0, 16'd200, 16'd100);
    clock_ms = $urandom;
    random_phase(100, 1'b0);
    drain();

    // Random settings
    set_regs(16'($urandom_range(5, 500)), 16'($urandom_range(0, 3000)),
             16'($urandom_range(100, 20000)));
    clock_ms = $urandom;
    master_ofs = 64'd1633942188000 + 64'($urandom_range(0, 1000));
    random_phase(200, 1'b0);
    drain();

    if (errors == 0) begin
      $display("ptp_sync_clock_servo regression: pass");
    end else begin
      $display("ptp_sync_clock_servo regression: fail");
    end
    $finish;
  end

endmodule
